// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define HRP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrp assertion failed");

// Next-cycle implication, disabled while reset is held.
`define HRP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrp assertion failed");

`endif

// ===== hdl/hrp_pkg.sv =====
// Package with event codes, character constants, the queue depth and the result word type.
`timescale 1ns / 1ps
package hrp_pkg;

  localparam logic [2:0] EV_VERB     = 3'd0;
  localparam logic [2:0] EV_RESOURCE = 3'd1;
  localparam logic [2:0] EV_VERSION  = 3'd2;
  localparam logic [2:0] EV_HNAME    = 3'd3;
  localparam logic [2:0] EV_HVALUE   = 3'd4;
  localparam logic [2:0] EV_COMPLETE = 3'd5;
  localparam logic [2:0] EV_ERROR    = 3'd6;

  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [7:0] TERM_TEXT [4] = '{CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF};

  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] span_start;
    logic [15:0] span_end;
    logic [7:0]  header_number;
    logic        last_of_run;
  } result_t;

endpackage

// ===== hdl/http_request_line_header_parser.sv =====
// HTTP GET request line and header parser, one byte per clock in while in_stall is low, span events out.
//
// Request text enters one byte per word on the in_ channel, with
// in_end_of_buffer set on the last byte of each buffer. Spans for the verb,
// resource, version and every header name and value, then one completion or
// error event, leave on the out_ channel. A word moves on either channel at a
// clock edge where valid is high and stall is low.
//
// An accepted byte is held in the input register, then parsed, and its
// events go into the result queue, whose head word drives the out_ ports.
// Throughput: one byte per cycle while the queue has room. A single pass of
// logic parses each byte, and its zero, one or two events go into a
// four-entry result queue. A byte is parsed only while the queue holds at
// most two words. Only the byte that ends a request gives two events, so with
// a ready receiver the input never waits.
//
// Reset (rst_n low, synchronous) empties the queue and returns the parser to
// the start of a request, as does every end-of-buffer byte. While out_stall is
// high the head word holds steady; input keeps flowing until the queue holds
// three words, and then in_stall rises.
`timescale 1ns / 1ps
module http_request_line_header_parser import hrp_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_buffer,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_kind,
  output logic [15:0] out_span_start,
  output logic [15:0] out_span_end,
  output logic [7:0]  out_header_number,
  output logic        out_last_of_run
);

  typedef enum logic [3:0] {
    PH_G, PH_E, PH_T, PH_VERB, PH_SP1, PH_RES, PH_SP2, PH_VER,
    PH_TERM, PH_SKIP, PH_HNAME, PH_COLON, PH_VSKIP, PH_VALUE
  } phase_t;

  typedef logic [POSITION_BITS-1:0] pos_t;

  // Offsets leave the block in their low 16 bits.
  function automatic logic [15:0] to16(input pos_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  // Input register.
  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       eob_r;

  // Parser state.
  phase_t     phase_r, phase_nxt;
  pos_t       pos_r;
  pos_t       mark_r, mark_nxt;
  logic [1:0] prog_r, prog_nxt;
  logic [7:0] hc_r, hc_nxt;
  logic       fin_r, fin_nxt;

  // Result queue.
  result_t              q_r [QDEPTH];
  logic [QPTR_BITS-1:0] rd_ptr_r, wr_ptr_r;
  logic [QPTR_BITS:0]   count_r;

  logic    proc, pop, used, hc_inc;
  logic    ev0_vld, ev1_vld;
  result_t ev0, ev1;
  pos_t    p, np;
  logic    sp, colon, cr, crlf;
  logic [1:0] push_n;

  // A byte is parsed when the queue can take both events it may cause.
  assign proc     = in_vld_r && (count_r <= (QPTR_BITS+1)'(QDEPTH - 2));
  assign in_stall = in_vld_r && !proc;
  assign pop      = out_valid && !out_stall;

  assign p     = pos_r;
  assign np    = pos_r + pos_t'(1);
  assign sp    = (byte_r == CHAR_SPACE);
  assign colon = (byte_r == CHAR_COLON);
  assign cr    = (byte_r == CHAR_CR);
  assign crlf  = cr || (byte_r == CHAR_LF);

  // The parse walks at most a few phases per byte; every path through
  // those phases is written out here as one arm of the case.
  always_comb begin
    phase_nxt = phase_r;
    mark_nxt  = mark_r;
    prog_nxt  = prog_r;
    fin_nxt   = fin_r;
    hc_inc    = 1'b0;
    used      = 1'b0;
    ev0_vld   = 1'b0;
    ev1_vld   = 1'b0;
    ev0       = '0;
    ev1       = '0;
    if (!fin_r) begin
      case (phase_r)
        PH_E: begin
          if (byte_r != CHAR_E) begin
            ev0_vld = 1'b1; ev0.event_kind = EV_ERROR; fin_nxt = 1'b1;
          end else begin
            phase_nxt = PH_T; used = 1'b1;
          end
        end
        PH_T: begin
          if (byte_r != CHAR_T) begin
            ev0_vld = 1'b1; ev0.event_kind = EV_ERROR; fin_nxt = 1'b1;
          end else begin
            phase_nxt = PH_VERB; used = 1'b1;
          end
        end
        PH_VERB: begin
          used = 1'b1;
          if (sp) begin
            ev0_vld = 1'b1; ev0.event_kind = EV_VERB; ev0.span_end = to16(p);
            phase_nxt = PH_SP1;
          end
        end
        PH_SP1: begin
          used = 1'b1;
          if (!sp) begin
            mark_nxt = p; phase_nxt = PH_RES;
          end
        end
        PH_RES: begin
          used = 1'b1;
          if (sp) begin
            ev0_vld = 1'b1; ev0.event_kind = EV_RESOURCE;
            ev0.span_start = to16(mark_r); ev0.span_end = to16(p);
            phase_nxt = PH_SP2;
          end
        end
        PH_SP2, PH_VSKIP, PH_VER, PH_VALUE: begin
          if ((phase_r inside {PH_SP2, PH_VSKIP}) && sp) begin
            used = 1'b1;
          end else if (!crlf) begin
            used = 1'b1;
            if (phase_r inside {PH_SP2, PH_VSKIP}) mark_nxt = p;
            phase_nxt = (phase_r inside {PH_SP2, PH_VER}) ? PH_VER : PH_VALUE;
          end else begin
            // Line end closes the field; an empty field starts here.
            ev0_vld = 1'b1;
            ev0.event_kind = (phase_r inside {PH_SP2, PH_VER}) ? EV_VERSION : EV_HVALUE;
            hc_inc = !(phase_r inside {PH_SP2, PH_VER});
            ev0.span_start = (phase_r inside {PH_SP2, PH_VSKIP}) ? to16(p) : to16(mark_r);
            ev0.span_end = to16(p);
            mark_nxt = p;
            used = 1'b1;
            // The same byte is the first one tried against the terminator.
            if (cr) begin
              prog_nxt = 2'd1; phase_nxt = PH_TERM;
              if (eob_r) begin
                ev1_vld = 1'b1; ev1.event_kind = EV_COMPLETE;
                ev1.span_start = to16(p); ev1.span_end = to16(np);
                fin_nxt = 1'b1;
              end
            end else begin
              prog_nxt = 2'd0; phase_nxt = PH_SKIP;
            end
          end
        end
        PH_TERM, PH_SKIP: begin
          if (phase_r == PH_TERM && byte_r == TERM_TEXT[prog_r]) begin
            used = 1'b1;
            prog_nxt = prog_r + 2'd1;
            if (prog_r == 2'd3 || eob_r) begin
              ev0_vld = 1'b1; ev0.event_kind = EV_COMPLETE;
              ev0.span_start = to16(mark_r); ev0.span_end = to16(np);
              fin_nxt = 1'b1;
            end
          end else begin
            prog_nxt = 2'd0;
            used = 1'b1;
            if (crlf || sp) begin
              phase_nxt = PH_SKIP;
            end else begin
              mark_nxt = p;
              if (colon) begin
                // Header with an empty name.
                ev0_vld = 1'b1; ev0.event_kind = EV_HNAME;
                ev0.span_start = to16(p); ev0.span_end = to16(p);
                phase_nxt = PH_VSKIP;
              end else begin
                phase_nxt = PH_HNAME;
              end
            end
          end
        end
        PH_HNAME: begin
          if (sp || colon || crlf) begin
            ev0_vld = 1'b1; ev0.event_kind = EV_HNAME;
            ev0.span_start = to16(mark_r); ev0.span_end = to16(p);
          end
          if (crlf) begin
            ev1_vld = 1'b1; ev1.event_kind = EV_ERROR;
            ev1.span_start = to16(p); ev1.span_end = to16(p);
            fin_nxt = 1'b1;
            phase_nxt = PH_COLON;
          end else begin
            used = 1'b1;
            if (colon) phase_nxt = PH_VSKIP;
            else if (sp) phase_nxt = PH_COLON;
          end
        end
        PH_COLON: begin
          if (crlf) begin
            ev0_vld = 1'b1; ev0.event_kind = EV_ERROR;
            ev0.span_start = to16(p); ev0.span_end = to16(p);
            fin_nxt = 1'b1;
          end else begin
            used = 1'b1;
            if (colon) phase_nxt = PH_VSKIP;
          end
        end
        default: begin
          // First verb character; unused phase codes land here too.
          if (byte_r != CHAR_G) begin
            ev0_vld = 1'b1; ev0.event_kind = EV_ERROR; fin_nxt = 1'b1;
          end else begin
            phase_nxt = PH_E; used = 1'b1;
          end
        end
      endcase
    end

    hc_nxt = (hc_inc && hc_r != 8'hFF) ? hc_r + 8'd1 : hc_r;

    // A buffer that ends inside a field or a space run is an error just past it.
    if (used && !fin_nxt && eob_r) begin
      fin_nxt = 1'b1;
      if (!ev0_vld) begin
        ev0_vld = 1'b1; ev0.event_kind = EV_ERROR;
        ev0.span_start = to16(np); ev0.span_end = to16(np);
      end else begin
        ev1_vld = 1'b1; ev1.event_kind = EV_ERROR;
        ev1.span_start = to16(np); ev1.span_end = to16(np);
      end
    end

    // Only a header value advances the count, and it is always the first event.
    ev0.header_number = hc_r;
    ev1.header_number = hc_nxt;
    ev0.last_of_run   = !ev1_vld;
    ev1.last_of_run   = 1'b1;
  end

  assign push_n = proc ? {1'b0, ev0_vld} + {1'b0, ev1_vld} : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      phase_r  <= PH_G;
      pos_r    <= '0;
      mark_r   <= '0;
      prog_r   <= 2'd0;
      hc_r     <= 8'd0;
      fin_r    <= 1'b0;
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
        byte_r   <= in_data_byte;
        eob_r    <= in_end_of_buffer;
      end
      if (proc) begin
        if (eob_r) begin
          phase_r <= PH_G;
          pos_r   <= '0;
          mark_r  <= '0;
          prog_r  <= 2'd0;
          hc_r    <= 8'd0;
          fin_r   <= 1'b0;
        end else begin
          phase_r <= phase_nxt;
          pos_r   <= np;
          mark_r  <= mark_nxt;
          prog_r  <= prog_nxt;
          hc_r    <= hc_nxt;
          fin_r   <= fin_nxt;
        end
        if (ev0_vld) q_r[wr_ptr_r] <= ev0;
        if (ev1_vld) q_r[wr_ptr_r + QPTR_BITS'(1)] <= ev1;
        wr_ptr_r <= wr_ptr_r + QPTR_BITS'(push_n);
      end
      if (pop) rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      count_r <= count_r + (QPTR_BITS+1)'(push_n) - (QPTR_BITS+1)'(pop);
    end
  end

  assign out_valid         = (count_r != '0);
  assign out_event_kind    = q_r[rd_ptr_r].event_kind;
  assign out_span_start    = q_r[rd_ptr_r].span_start;
  assign out_span_end      = q_r[rd_ptr_r].span_end;
  assign out_header_number = q_r[rd_ptr_r].header_number;
  assign out_last_of_run   = q_r[rd_ptr_r].last_of_run;

endmodule

// ===== hdl/hrp_checker.sv =====
// Port-level checker for the request parser and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hrp_checker import hrp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_event_kind,
  input logic [15:0] out_span_start,
  input logic [15:0] out_span_end,
  input logic [7:0]  out_header_number,
  input logic        out_last_of_run
);

  // A stalled result word must hold.
  `HRP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_event_kind) && $stable(out_span_start) &&
    $stable(out_span_end) && $stable(out_header_number) && $stable(out_last_of_run))

  // Errors point at one position and carry no length.
  `HRP_ASSERT_IMP(a_err_empty, clk, rst_n, out_valid && out_event_kind == EV_ERROR,
    out_span_start == out_span_end)

  // Completion and error end the events of their byte.
  `HRP_ASSERT_IMP(a_final_last, clk, rst_n,
    out_valid && (out_event_kind == EV_COMPLETE || out_event_kind == EV_ERROR),
    out_last_of_run)

  // The verb always starts the request at offset zero, before any header.
  `HRP_ASSERT_IMP(a_verb_start, clk, rst_n, out_valid && out_event_kind == EV_VERB,
    out_span_start == 16'd0 && out_header_number == 8'd0)

  // The input only waits while result words are queued.
  `HRP_ASSERT_IMP(a_stall_busy, clk, rst_n, in_stall, out_valid)

endmodule

bind http_request_line_header_parser hrp_checker u_hrp_checker (.*);
